### rtl/core/rkrf_pkg.sv
// Shared types and constants for the remote key repeat filter.
// Holds the beat structs, queue entry type, key code reset table and holdoff constants.
// No dependencies.
package rkrf_pkg;

  localparam int unsigned NumCodes    = 8;
  localparam int unsigned CodeWidth   = 48;
  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned VolWidth    = 7;
  localparam int unsigned CmdWidth    = 3;
  localparam int unsigned LastWidth   = 4;
  localparam int unsigned ApbDataW    = 64;
  localparam int unsigned ApbAddrW    = 6;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [TimeWidth-1:0] ShortHoldoffUs = 32'd100000;
  localparam logic [TimeWidth-1:0] LongHoldoffUs  = 32'd300000;
  localparam logic [VolWidth-1:0]  VolumeStep     = 7'd5;
  localparam logic [VolWidth-1:0]  VolumeMax      = 7'd100;

  localparam logic [CmdWidth-1:0]  CmdVolUp   = 3'd5;
  localparam logic [CmdWidth-1:0]  CmdVolDown = 3'd6;
  localparam logic [LastWidth-1:0] NoCommand  = 4'd15;

  typedef logic [NumCodes-1:0][CodeWidth-1:0] code_table_t;

  // entry i is the reset code of command i
  localparam code_table_t CodeReset = {
    48'h43179c000000, 48'h463738000000, 48'h4237b8000000, 48'h4037f8000000,
    48'h4217bc000000, 48'h46173c000000, 48'h4017fc000000, 48'h4297ac000000
  };

  typedef struct packed {
    logic [CodeWidth-1:0] key_code;
    logic [TimeWidth-1:0] time_us;
    logic [VolWidth-1:0]  volume_now;
  } in_item_t;

  typedef struct packed {
    logic                matched;
    logic                accepted;
    logic [CmdWidth-1:0] command_index;
    logic [VolWidth-1:0] volume_new;
    logic                volume_changed;
  } out_item_t;

  // classified key waiting for the filter
  typedef struct packed {
    logic                 matched;
    logic [CmdWidth-1:0]  cmd_idx;
    logic [TimeWidth-1:0] time_us;
    logic [VolWidth-1:0]  volume_now;
  } class_t;

endpackage

### rtl/core/rkrf_front.sv
// Front end of the remote key repeat filter: matches key codes against the table.
// Depends on rkrf_pkg.
module rkrf_front (
  input  rkrf_pkg::in_item_t    in_item_i,
  input  rkrf_pkg::code_table_t codes_i,
  output rkrf_pkg::class_t      class_o
);

  logic [rkrf_pkg::NumCodes-1:0] hit;

  always_comb begin
    for (int i = 0; i < int'(rkrf_pkg::NumCodes); i++) begin
      hit[i] = (codes_i[i] == in_item_i.key_code);
    end
  end

  // lowest index wins on duplicate codes
  always_comb begin
    class_o.matched    = |hit;
    class_o.cmd_idx    = '0;
    class_o.time_us    = in_item_i.time_us;
    class_o.volume_now = in_item_i.volume_now;
    for (int i = int'(rkrf_pkg::NumCodes) - 1; i >= 0; i--) begin
      if (hit[i]) begin
        class_o.cmd_idx = rkrf_pkg::CmdWidth'(i);
      end
    end
  end

endmodule

### rtl/core/rkrf_queue.sv
// Short queue between front and back of the remote key repeat filter.
// Depends on rkrf_pkg for the entry type.
module rkrf_queue #(
  parameter int unsigned Depth = rkrf_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rkrf_pkg::class_t wr_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output rkrf_pkg::class_t rd_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rkrf_pkg::class_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign rd_entry_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

### rtl/core/rkrf_back.sv
// Back end of the remote key repeat filter: repeat holdoff, volume step, output register.
// Depends on rkrf_pkg.
module rkrf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  rkrf_pkg::class_t   q_entry_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rkrf_pkg::out_item_t out_item_o
);

  logic [rkrf_pkg::LastWidth-1:0] last_cmd_q, last_cmd_d;
  logic [rkrf_pkg::TimeWidth-1:0] last_time_q, last_time_d;
  logic                           short_q, short_d;
  logic                           out_valid_q;
  rkrf_pkg::out_item_t            out_item_q, out_item_d;

  logic [rkrf_pkg::TimeWidth-1:0] elapsed, hold;
  logic                           accept, is_vol, is_up;
  logic [rkrf_pkg::VolWidth:0]    vol_up_sum;
  logic [rkrf_pkg::VolWidth-1:0]  vol_dn, vol_step;

  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign elapsed = q_entry_i.time_us - last_time_q;
  assign hold    = short_q ? rkrf_pkg::ShortHoldoffUs : rkrf_pkg::LongHoldoffUs;
  assign accept  = q_entry_i.matched &&
                   (({1'b0, q_entry_i.cmd_idx} != last_cmd_q) || (elapsed > hold));
  assign is_up   = (q_entry_i.cmd_idx == rkrf_pkg::CmdVolUp);
  assign is_vol  = is_up || (q_entry_i.cmd_idx == rkrf_pkg::CmdVolDown);

  // saturate at zero and at VolumeMax
  always_comb begin
    vol_up_sum = {1'b0, q_entry_i.volume_now} + {1'b0, rkrf_pkg::VolumeStep};
    if (q_entry_i.volume_now < rkrf_pkg::VolumeStep) begin
      vol_dn = '0;
    end else begin
      vol_dn = q_entry_i.volume_now - rkrf_pkg::VolumeStep;
    end
    if (is_up) begin
      vol_step = (vol_up_sum > {1'b0, rkrf_pkg::VolumeMax}) ? rkrf_pkg::VolumeMax
                                                          : vol_up_sum[rkrf_pkg::VolWidth-1:0];
    end else begin
      vol_step = (vol_dn > rkrf_pkg::VolumeMax) ? rkrf_pkg::VolumeMax : vol_dn;
    end
  end

  always_comb begin
    last_cmd_d  = last_cmd_q;
    last_time_d = last_time_q;
    short_d     = short_q;
    out_item_d.matched        = q_entry_i.matched;
    out_item_d.accepted       = accept;
    out_item_d.command_index  = q_entry_i.cmd_idx;
    out_item_d.volume_new     = q_entry_i.volume_now;
    out_item_d.volume_changed = 1'b0;
    if (accept) begin
      last_cmd_d  = {1'b0, q_entry_i.cmd_idx};
      last_time_d = q_entry_i.time_us;
      short_d     = is_vol;
      if (is_vol) begin
        out_item_d.volume_new     = vol_step;
        out_item_d.volume_changed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cmd_q  <= rkrf_pkg::NoCommand;
      last_time_q <= '0;
      short_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        last_cmd_q  <= last_cmd_d;
        last_time_q <= last_time_d;
        short_q     <= short_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

### rtl/core/remote_key_repeat_filter.sv
// Remote key repeat filter, top level.
// Input beats carry a key code, a microsecond timestamp and the current volume;
// each yields exactly one output beat with match, accept, command and volume fields.
// Both channels use valid/ready; a beat moves when valid and ready are high together.
// Eight 48-bit key codes sit behind an APB port at byte addresses 8*i (64-bit data);
// write them only while the block is idle.
// An input beat is classified into the queue, then filtered into the output register.
// Throughput: one beat per cycle while out_ready_i stays high; the filter state update
// is a registered loop of one 32-bit subtract and compare in the back end.
// The front takes beats while the queue has room, so a stalled receiver first
// fills the output register, then the queue, and only then drops in_ready_o.
// Reset restores the default key codes, clears the queue and output register,
// and forgets the last key so the first known key is always accepted.
// Depends on rkrf_pkg, rkrf_front, rkrf_queue and rkrf_back.
module remote_key_repeat_filter #(
  parameter int unsigned QueueDepth = rkrf_pkg::QueueDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rkrf_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rkrf_pkg::out_item_t            out_item_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rkrf_pkg::ApbAddrW-1:0]  paddr,
  input  logic [rkrf_pkg::ApbDataW-1:0]  pwdata,
  output logic [rkrf_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);

  rkrf_pkg::code_table_t codes_q;
  rkrf_pkg::class_t      front_class, q_entry;
  logic                  q_full, q_valid, q_pop, push;
  logic [2:0]            reg_idx;

  assign pready     = 1'b1;
  assign reg_idx    = paddr[5:3];
  assign prdata     = {{(rkrf_pkg::ApbDataW - rkrf_pkg::CodeWidth){1'b0}}, codes_q[reg_idx]};
  assign in_ready_o = !q_full;
  assign push       = in_valid_i && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q <= rkrf_pkg::CodeReset;
    end else if (psel && penable && pwrite) begin
      codes_q[reg_idx] <= pwdata[rkrf_pkg::CodeWidth-1:0];
    end
  end

  rkrf_front u_front (
    .in_item_i (in_item_i),
    .codes_i   (codes_q),
    .class_o   (front_class)
  );

  rkrf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .wr_entry_i (front_class),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .rd_entry_o (q_entry)
  );

  rkrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

### dv/rkrf_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the remote key repeat filter: key match and repeat-holdoff predictor
// plus an in-order store of expected result beats. Depends on rkrf_pkg.
package rkrf_scoreboard_pkg;

  import rkrf_pkg::*;

  class key_filter_scoreboard;
    logic [CodeWidth-1:0] codes [NumCodes];
    logic [LastWidth-1:0] last_cmd;
    logic [TimeWidth-1:0] last_stamp;
    bit                   short_hold;
    out_item_t            expected_results [$];
    int unsigned          errors;

    function new();
      foreach (codes[i]) codes[i] = CodeReset[i];
      last_cmd   = NoCommand;
      last_stamp = '0;
      short_hold = 1'b0;
      errors     = 0;
    endfunction

    function void set_code(int unsigned idx, logic [CodeWidth-1:0] value);
      codes[idx] = value;
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

    // step by the volume increment, then clamp into 0..100
    function logic [VolWidth-1:0] stepped_volume(logic [VolWidth-1:0] level, bit up);
      int vol = level;
      if (up) begin
        vol = vol + int'(VolumeStep);
      end else begin
        vol = (vol < int'(VolumeStep)) ? 0 : vol - int'(VolumeStep);
      end
      if (vol > int'(VolumeMax)) vol = int'(VolumeMax);
      return VolWidth'(vol);
    endfunction

    function out_item_t filter_key(in_item_t beat);
      out_item_t            res;
      logic [TimeWidth-1:0] elapsed;
      logic [TimeWidth-1:0] hold;
      logic [CmdWidth-1:0]  idx;
      bit                   hit;
      res            = '0;
      res.volume_new = beat.volume_now;
      idx            = '0;
      hit            = 1'b0;
      // scan downwards so the lowest matching register wins
      for (int i = NumCodes - 1; i >= 0; i--) begin
        if (codes[i] == beat.key_code) begin
          hit = 1'b1;
          idx = CmdWidth'(i);
        end
      end
      res.matched       = hit;
      res.command_index = idx;
      if (hit) begin
        elapsed = beat.time_us - last_stamp;
        hold    = short_hold ? ShortHoldoffUs : LongHoldoffUs;
        if ({1'b0, idx} != last_cmd || elapsed > hold) begin
          res.accepted = 1'b1;
          last_cmd     = {1'b0, idx};
          last_stamp   = beat.time_us;
          if (idx == CmdVolUp || idx == CmdVolDown) begin
            short_hold         = 1'b1;
            res.volume_new     = stepped_volume(beat.volume_now, idx == CmdVolUp);
            res.volume_changed = 1'b1;
          end else begin
            short_hold = 1'b0;
          end
        end
      end
      return res;
    endfunction

    function void note_key_beat(in_item_t beat);
      expected_results.push_back(filter_key(beat));
    endfunction

    function void flag_field(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_result_beat(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat %h with nothing expected", $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.matched !== want.matched) flag_field("matched", want.matched, got.matched);
      if (got.accepted !== want.accepted) flag_field("accepted", want.accepted, got.accepted);
      if (got.command_index !== want.command_index) begin
        flag_field("command_index", want.command_index, got.command_index);
      end
      if (got.volume_new !== want.volume_new) begin
        flag_field("volume_new", want.volume_new, got.volume_new);
      end
      if (got.volume_changed !== want.volume_changed) begin
        flag_field("volume_changed", want.volume_changed, got.volume_changed);
      end
    endfunction
  endclass

endpackage

### dv/remote_key_repeat_filter_tb.sv
`timescale 1ns / 100ps
// Top-level testbench for remote_key_repeat_filter: directed and random key beats,
// APB key code rewrites between phases, random back-pressure. Depends on rkrf_pkg
// and rkrf_scoreboard_pkg.
module remote_key_repeat_filter_tb;

  import rkrf_pkg::*;
  import rkrf_scoreboard_pkg::*;

  localparam int unsigned IdleLimit      = 4000;
  localparam int unsigned LongStall      = 300;
  localparam int unsigned RandomPerPhase = 255;
  localparam int unsigned PressureBeats  = 24;
  localparam int unsigned ApbStride      = 8;

  typedef enum int unsigned {
    RegPlay, RegStop, RegNext, RegPrev, RegQuit, RegVolUp, RegVolDown, RegPause
  } key_reg_e;

  typedef enum int unsigned {
    CfgExtremes, CfgDuplicates, CfgRandomA, CfgRandomB, CfgDefaults
  } key_set_e;

  typedef enum int unsigned {RxOpen, RxCoin, RxSparse, RxPattern} rx_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ApbAddrW-1:0] paddr       = '0;
  logic [ApbDataW-1:0] pwdata      = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  key_filter_scoreboard sb = new();
  in_item_t             stim_q [$];
  logic [CodeWidth-1:0] prev_key = '0;
  logic [TimeWidth-1:0] clock_us = '0;
  bit                   long_stall_req = 1'b0;
  int unsigned          quiet_cycles = 0;

  remote_key_repeat_filter dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_key_beat(in_item_i);
      if (out_valid_o && out_ready_i) sb.check_result_beat(out_item_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("remote_key_repeat_filter verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: switch stall pattern now and then, or hold off on request
  initial begin : receiver
    int unsigned tick;
    rx_mode_e    mode;
    tick = 0;
    mode = RxOpen;
    forever begin
      @(posedge clk_i);
      tick++;
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongStall) @(posedge clk_i);
      end else begin
        if (tick % 97 == 0) mode = rx_mode_e'($urandom_range(3, 0));
        case (mode)
          RxOpen:   out_ready_i <= 1'b1;
          RxCoin:   out_ready_i <= 1'($urandom_range(1, 0));
          RxSparse: out_ready_i <= ($urandom_range(3, 0) == 0);
          default:  out_ready_i <= (tick % 8 < 5);
        endcase
      end
    end
  end

  function automatic logic [CodeWidth-1:0] random_code();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[CodeWidth-1:0];
  endfunction

  // mostly known keys and repeats, time steps around the holdoffs, volume at its edges
  function automatic in_item_t random_beat();
    in_item_t    beat;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 40) beat.key_code = prev_key;
    else if (pick < 85) beat.key_code = sb.codes[$urandom_range(NumCodes - 1, 0)];
    else beat.key_code = random_code();
    prev_key = beat.key_code;

    pick = $urandom_range(99, 0);
    if (pick < 5) begin
      clock_us = $urandom;
    end else if (pick < 25) begin
      clock_us = clock_us + $urandom_range(99999, 0);
    end else if (pick < 45) begin
      clock_us = clock_us + ($urandom_range(1, 0) ? ShortHoldoffUs : LongHoldoffUs)
                 + $urandom_range(2, 0) - 1;
    end else if (pick < 65) begin
      clock_us = clock_us + $urandom_range(400000, 100000);
    end else if (pick < 75) begin
      clock_us = clock_us + 32'hFFFF_0000 + $urandom_range(4095, 0);
    end else begin
      clock_us = clock_us + $urandom_range(2000, 0);
    end
    beat.time_us = clock_us;

    pick = $urandom_range(99, 0);
    if (pick < 70) begin
      beat.volume_now = VolWidth'($urandom_range(100, 0));
    end else if (pick < 85) begin
      beat.volume_now = VolWidth'($urandom_range(1, 0) ? $urandom_range(6, 0)
                                                       : $urandom_range(100, 94));
    end else begin
      beat.volume_now = VolWidth'($urandom_range(127, 101));
    end
    return beat;
  endfunction

  task automatic queue_beat(input logic [CodeWidth-1:0] key,
                            input logic [TimeWidth-1:0] stamp,
                            input logic [VolWidth-1:0] vol);
    in_item_t beat;
    beat.key_code   = key;
    beat.time_us    = stamp;
    beat.volume_now = vol;
    stim_q.push_back(beat);
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) stim_q.push_back(random_beat());
  endtask

  task automatic send_beat(input in_item_t beat);
    in_valid_i <= 1'b1;
    in_item_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drive_queue(input bit bursty);
    int unsigned burst;
    int unsigned gap;
    @(posedge clk_i);
    while (stim_q.size() != 0) begin
      burst = bursty ? $urandom_range(12, 1) : stim_q.size();
      while (burst != 0 && stim_q.size() != 0) begin
        send_beat(stim_q.pop_front());
        burst--;
      end
      gap = (!bursty || $urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 1);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_for_drain();
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_key_code(input key_reg_e reg_idx, input logic [CodeWidth-1:0] code);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(reg_idx * ApbStride);
    pwdata  <= ApbDataW'(code);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_code(reg_idx, code);
  endtask

  initial begin : stimulus
    key_set_e             plan [5];
    logic [CodeWidth-1:0] code;
    plan = '{CfgExtremes, CfgDuplicates, CfgRandomA, CfgRandomB, CfgDefaults};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: unknown keys, holdoff boundaries, volume saturation, timer wrap
    queue_beat('0, '0, '0);
    queue_beat('1, '1, '1);
    queue_beat(sb.codes[RegPlay], 32'd1000, 7'd50);
    queue_beat(sb.codes[RegPlay], 32'd301000, 7'd50);
    queue_beat(sb.codes[RegPlay], 32'd301001, 7'd50);
    queue_beat(sb.codes[RegStop], 32'd301002, 7'd0);
    queue_beat(sb.codes[RegVolUp], 32'd301003, 7'd98);
    queue_beat(sb.codes[RegVolUp], 32'd401003, 7'd100);
    queue_beat(sb.codes[RegVolUp], 32'd401004, 7'd100);
    queue_beat(sb.codes[RegVolDown], 32'd401005, 7'd3);
    queue_beat(sb.codes[RegVolDown], 32'd501006, 7'd127);
    queue_beat(sb.codes[RegVolUp], 32'd501007, 7'd120);
    queue_beat(sb.codes[RegVolDown], 32'd501008, 7'd0);
    queue_beat(sb.codes[RegVolDown], 32'd501009, 7'd127);
    queue_beat(sb.codes[RegNext], 32'd501010, 7'd64);
    queue_beat(sb.codes[RegPrev], 32'd501011, 7'd64);
    queue_beat(sb.codes[RegQuit], 32'd501012, 7'd64);
    queue_beat(sb.codes[RegPause], 32'hFFFF_FF00, 7'd1);
    queue_beat(sb.codes[RegPause], 32'h0000_0010, 7'd1);
    queue_beat(sb.codes[RegPause], 32'h0004_9400, 7'd1);
    queue_beat(sb.codes[RegPlay], 32'h0004_9401, 7'd127);
    drive_queue(1'b1);

    clock_us = $urandom;
    queue_random(RandomPerPhase);
    drive_queue(1'b1);

    foreach (plan[p]) begin
      wait_for_drain();
      repeat (3) @(posedge clk_i);
      for (int i = 0; i < NumCodes; i++) begin
        case (plan[p])
          CfgExtremes: begin
            code = (i == RegPlay) ? '0 : (i == RegStop) ? '1 : random_code();
          end
          CfgDuplicates: begin
            code = (i == RegVolDown) ? sb.codes[RegStop]
                 : (i == RegPause)   ? sb.codes[RegVolUp] : random_code();
          end
          CfgDefaults: code = CodeReset[i];
          default:     code = random_code();
        endcase
        write_key_code(key_reg_e'(i), code);
      end
      queue_random(RandomPerPhase);
      drive_queue(1'b1);
      if (plan[p] == CfgExtremes) begin
        // hold the output off while beats keep coming, so the input stalls
        long_stall_req = 1'b1;
        queue_random(PressureBeats);
        drive_queue(1'b0);
      end
    end

    wait_for_drain();
    repeat (10) @(posedge clk_i);
    if (sb.outstanding() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time, sb.outstanding());
    end
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("remote_key_repeat_filter verification clean");
    end else begin
      $display("remote_key_repeat_filter verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rkrf_pkg.sv
rtl/core/rkrf_front.sv
rtl/core/rkrf_queue.sv
rtl/core/rkrf_back.sv
rtl/core/remote_key_repeat_filter.sv
dv/rkrf_scoreboard_pkg.sv
dv/remote_key_repeat_filter_tb.sv
